// ===== design/assert_macros.svh =====
// Assertion helpers shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");
`define ASSERT_ALW(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif

`endif

// ===== design/ukcd_pkg.sv =====
package ukcd_pkg;

  localparam int LINE_BYTES_DEF = 32;

  localparam logic [15:0] RELOAD_RESET = 16'd999;

  // result kinds
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_SERVO = 2'd1;
  localparam logic [1:0] KIND_MOTOR = 2'd2;

  // motor direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] KEY_SERVO = 8'd120;  // 'x'
  localparam logic [7:0] KEY_FWD   = 8'd122;  // 'z'
  localparam logic [7:0] KEY_REV   = 8'd114;  // 'r'

  localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
  localparam logic [15:0] SERVO_MID = 16'd1470;
  // pulse for the positive saturated value 2^31-1, low 16 bits
  localparam logic [15:0] SERVO_POS_SAT =
    16'((64'd1470 + (64'd330 * 64'd2147483647) / 64'd34) & 64'hFFFF);
  localparam logic [6:0]  DUTY_MAX = 7'd100;

  // motor compare = (duty * scale) >> SCALE_SHIFT, scale = ceil(reload * 2^14 / 100)
  localparam int SCALE_SHIFT = 14;
  localparam int SCALE_W     = 24;
  // floor(x / 25) = (x * RECIP25) >> 21 for any 16-bit x
  localparam logic [16:0] RECIP25       = 17'd83887;
  localparam int          RECIP25_SHIFT = 21;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_KEY,
    PH_VLEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  echo_byte;
    logic [15:0] servo_pulse;
    logic [1:0]  motor_dir;
    logic [15:0] motor_compare;
  } out_beat_t;

  typedef logic [15:0] cfg_beat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  // quotient by 17 of a value below 170
  function automatic logic [3:0] div17(input logic [7:0] t);
    logic [3:0] q;
    q = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (t >= 8'(17 * i)) q = 4'(i);
    end
    return q;
  endfunction

  // floor(165 * r / 17) for r in 0..16
  function automatic logic [7:0] frac165(input logic [4:0] r);
    logic [7:0] f;
    case (r)
      5'd0:    f = 8'd0;
      5'd1:    f = 8'd9;
      5'd2:    f = 8'd19;
      5'd3:    f = 8'd29;
      5'd4:    f = 8'd38;
      5'd5:    f = 8'd48;
      5'd6:    f = 8'd58;
      5'd7:    f = 8'd67;
      5'd8:    f = 8'd77;
      5'd9:    f = 8'd87;
      5'd10:   f = 8'd97;
      5'd11:   f = 8'd106;
      5'd12:   f = 8'd116;
      5'd13:   f = 8'd126;
      5'd14:   f = 8'd135;
      5'd15:   f = 8'd145;
      5'd16:   f = 8'd155;
      default: f = 8'd0;
    endcase
    return f;
  endfunction

  // ceil(4096 * b / 25) for b in 0..24
  function automatic logic [11:0] ceil_frac25(input logic [4:0] b);
    logic [11:0] f;
    case (b)
      5'd0:    f = 12'd0;
      5'd1:    f = 12'd164;
      5'd2:    f = 12'd328;
      5'd3:    f = 12'd492;
      5'd4:    f = 12'd656;
      5'd5:    f = 12'd820;
      5'd6:    f = 12'd984;
      5'd7:    f = 12'd1147;
      5'd8:    f = 12'd1311;
      5'd9:    f = 12'd1475;
      5'd10:   f = 12'd1639;
      5'd11:   f = 12'd1803;
      5'd12:   f = 12'd1967;
      5'd13:   f = 12'd2130;
      5'd14:   f = 12'd2294;
      5'd15:   f = 12'd2458;
      5'd16:   f = 12'd2622;
      5'd17:   f = 12'd2786;
      5'd18:   f = 12'd2950;
      5'd19:   f = 12'd3113;
      5'd20:   f = 12'd3277;
      5'd21:   f = 12'd3441;
      5'd22:   f = 12'd3605;
      5'd23:   f = 12'd3769;
      5'd24:   f = 12'd3933;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

  // ceil(reload * 2^14 / 100) = 4096 * (reload / 25) + ceil(4096 * (reload % 25) / 25)
  function automatic logic [SCALE_W-1:0] reload_scale(input logic [15:0] reload);
    logic [32:0] prod;
    logic [11:0] q;
    logic [15:0] rem;
    prod = 33'(reload) * 33'(RECIP25);
    q    = prod[RECIP25_SHIFT +: 12];
    rem  = reload - ({q, 4'b0} + {1'b0, q, 3'b0} + {4'b0, q});
    return {q, 12'b0} + 24'(ceil_frac25(rem[4:0]));
  endfunction

  localparam logic [SCALE_W-1:0] SCALE_RESET = reload_scale(RELOAD_RESET);

endpackage

// ===== design/ukcd_chan_if.sv =====
interface ukcd_chan_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ukcd_line.sv =====
`include "assert_macros.svh"

module ukcd_line #(
  parameter int LINE_BYTES = ukcd_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [7:0]                        rx_byte,
  input  logic [ukcd_pkg::SCALE_W-1:0]      scale,
  output logic                              res_vld,
  output ukcd_pkg::out_beat_t               res
);

  localparam int CW = $clog2(LINE_BYTES);
  localparam logic [CW-1:0] CNT_LAST = CW'(LINE_BYTES - 1);

  logic [CW-1:0]    cnt_r, cnt_nxt;
  ukcd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       key_r, key_nxt;
  logic [1:0]       klen_r, klen_nxt;
  logic [31:0]      mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic             bad_r, bad_nxt;
  logic             ended_r, ended_nxt;
  // magnitude tracked as 17*quo + rem, quo modulo 2^16, for the servo scaling
  logic [15:0]      quo_r, quo_nxt;
  logic [4:0]       rem_r, rem_nxt;

  logic        line_end;
  logic        take_digit;
  logic        clear_line;
  logic [3:0]  dig;
  logic [35:0] mag_x10;
  logic [31:0] mag_add;
  logic [7:0]  t17;
  logic [3:0]  tq;
  logic [7:0]  tq17;
  logic [15:0] quo_add;
  logic [4:0]  rem_add;

  assign line_end = (rx_byte == ukcd_pkg::CH_CR) || (rx_byte == ukcd_pkg::CH_LF);
  assign dig      = 4'(rx_byte - ukcd_pkg::CH_ZERO);

  always_comb begin
    mag_x10 = {1'b0, mag_r, 3'b0} + {3'b0, mag_r, 1'b0} + 36'(dig);
    mag_add = (mag_x10 > 36'(ukcd_pkg::MAG_CAP)) ? ukcd_pkg::MAG_CAP : mag_x10[31:0];
    t17     = 8'({rem_r, 3'b0}) + 8'({rem_r, 1'b0}) + 8'(dig);
    tq      = ukcd_pkg::div17(t17);
    tq17    = 8'({tq, 4'b0}) + 8'(tq);
    quo_add = {quo_r[12:0], 3'b0} + {quo_r[14:0], 1'b0} + 16'(tq);
    rem_add = 5'(t17 - tq17);
  end

  // next state
  always_comb begin
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    key_nxt    = key_r;
    klen_nxt   = klen_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    bad_nxt    = bad_r;
    ended_nxt  = ended_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    take_digit = 1'b0;
    clear_line = 1'b0;

    if (step) begin
      if (line_end || cnt_r >= CNT_LAST) begin
        clear_line = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (!ended_r) begin
          if (rx_byte == ukcd_pkg::CH_NUL) begin
            ended_nxt = 1'b1;
          end else if (!bad_r) begin
            case (phase_r)
              ukcd_pkg::PH_LEAD: begin
                if (ukcd_pkg::is_ws(rx_byte)) begin
                end else if (ukcd_pkg::is_alnum(rx_byte)) begin
                  key_nxt   = rx_byte;
                  klen_nxt  = 2'd1;
                  phase_nxt = ukcd_pkg::PH_KEY;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              ukcd_pkg::PH_KEY: begin
                if (rx_byte == ukcd_pkg::CH_EQ) begin
                  phase_nxt = ukcd_pkg::PH_VLEAD;
                end else if (ukcd_pkg::is_alnum(rx_byte) && klen_r == 2'd1) begin
                  klen_nxt = 2'd2;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              ukcd_pkg::PH_VLEAD: begin
                if (ukcd_pkg::is_ws(rx_byte)) begin
                end else if (rx_byte == ukcd_pkg::CH_PLUS || rx_byte == ukcd_pkg::CH_MINUS) begin
                  neg_nxt   = (rx_byte == ukcd_pkg::CH_MINUS);
                  phase_nxt = ukcd_pkg::PH_SIGN;
                end else if (ukcd_pkg::is_digit(rx_byte)) begin
                  take_digit = 1'b1;
                  phase_nxt  = ukcd_pkg::PH_DIGITS;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              ukcd_pkg::PH_SIGN: begin
                if (ukcd_pkg::is_digit(rx_byte)) begin
                  take_digit = 1'b1;
                  phase_nxt  = ukcd_pkg::PH_DIGITS;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              ukcd_pkg::PH_DIGITS: begin
                if (ukcd_pkg::is_digit(rx_byte)) begin
                  take_digit = 1'b1;
                end else if (ukcd_pkg::is_ws(rx_byte)) begin
                  phase_nxt = ukcd_pkg::PH_TRAIL;
                end else begin
                  bad_nxt = 1'b1;
                end
              end
              ukcd_pkg::PH_TRAIL: begin
                if (!ukcd_pkg::is_ws(rx_byte)) bad_nxt = 1'b1;
              end
              default: begin
                bad_nxt = 1'b1;
              end
            endcase
          end
        end
      end
    end

    if (take_digit) begin
      mag_nxt = mag_add;
      quo_nxt = quo_add;
      rem_nxt = rem_add;
    end

    if (clear_line) begin
      cnt_nxt   = '0;
      phase_nxt = ukcd_pkg::PH_LEAD;
      key_nxt   = '0;
      klen_nxt  = '0;
      mag_nxt   = '0;
      neg_nxt   = 1'b0;
      bad_nxt   = 1'b0;
      ended_nxt = 1'b0;
      quo_nxt   = '0;
      rem_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= ukcd_pkg::PH_LEAD;
      key_r   <= '0;
      klen_r  <= '0;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      ended_r <= 1'b0;
      quo_r   <= '0;
      rem_r   <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      key_r   <= key_nxt;
      klen_r  <= klen_nxt;
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      ended_r <= ended_nxt;
      quo_r   <= quo_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // result of the current byte
  logic        pos_sat;
  logic        line_ok;
  logic [15:0] ten_m;
  logic [23:0] q165;
  logic [15:0] servo_val;
  logic [7:0]  duty_raw;
  logic [6:0]  duty;
  logic [30:0] cmp_full;

  always_comb begin
    pos_sat = mag_r[31] && !neg_r;
    line_ok = (cnt_r != '0) && !bad_r && (klen_r == 2'd1) &&
              (phase_r == ukcd_pkg::PH_DIGITS || phase_r == ukcd_pkg::PH_TRAIL);

    ten_m = {mag_r[12:0], 3'b0} + {mag_r[14:0], 1'b0};
    q165  = 24'(quo_r) * 24'd165;
    if (neg_r) begin
      servo_val = ukcd_pkg::SERVO_MID - ten_m;
    end else if (pos_sat) begin
      servo_val = ukcd_pkg::SERVO_POS_SAT;
    end else begin
      servo_val = ukcd_pkg::SERVO_MID + q165[15:0] + 16'(ukcd_pkg::frac165(rem_r));
    end

    if (pos_sat) begin
      duty_raw = 8'hFF;
    end else if (neg_r && key_r == ukcd_pkg::KEY_FWD) begin
      duty_raw = 8'd0 - mag_r[7:0];
    end else begin
      duty_raw = mag_r[7:0];
    end
    duty     = (duty_raw > 8'(ukcd_pkg::DUTY_MAX)) ? ukcd_pkg::DUTY_MAX : duty_raw[6:0];
    cmp_full = 31'(duty) * 31'(scale);

    res_vld = 1'b0;
    res     = '0;
    if (line_end) begin
      if (line_ok && key_r == ukcd_pkg::KEY_SERVO) begin
        res_vld         = 1'b1;
        res.kind        = ukcd_pkg::KIND_SERVO;
        res.servo_pulse = servo_val;
      end else if (line_ok && (key_r == ukcd_pkg::KEY_FWD || key_r == ukcd_pkg::KEY_REV)) begin
        res_vld           = 1'b1;
        res.kind          = ukcd_pkg::KIND_MOTOR;
        res.motor_dir     = (key_r == ukcd_pkg::KEY_FWD) ? ukcd_pkg::DIR_FWD : ukcd_pkg::DIR_REV;
        res.motor_compare = cmp_full[ukcd_pkg::SCALE_SHIFT +: 16];
      end
    end else begin
      res_vld       = 1'b1;
      res.kind      = ukcd_pkg::KIND_ECHO;
      res.echo_byte = rx_byte;
    end
  end

  `ASSERT_CLK(a_cnt_bound, clk, rst_n, cnt_r <= CNT_LAST)
  `ASSERT_CLK(a_nul_counted, clk, rst_n, ended_r |-> cnt_r != '0)
  `ASSERT_CLK(a_mag_cap, clk, rst_n, mag_r[31] |-> mag_r[30:0] == '0)
  `ASSERT_CLK(a_key_phase, clk, rst_n, (phase_r == ukcd_pkg::PH_LEAD) == (klen_r == 2'd0))

endmodule

// ===== design/uart_kv_command_decoder_unit.sv =====
// Line-based KEY=VALUE command decoder for a serial receive stream. Every byte
// other than CR or LF comes back as an echo beat; CR or LF closes the line and,
// for a valid x, z or r command, yields one servo or motor beat. The block takes
// one byte per clock unless the output stalls: the byte is registered on accept,
// parsed combinationally against the line state, and its result is then held
// in the output register. A stall on the output holds the input stage; the
// input stays ready while the output register is free or being drained. A
// reload write applies to bytes accepted from the next cycle on; the duty scale
// factor derived from it is re-registered every cycle.
`include "assert_macros.svh"

module uart_kv_command_decoder_unit #(
  parameter int LINE_BYTES = ukcd_pkg::LINE_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ukcd_chan_if.sink    in_ch,
  ukcd_chan_if.source  out_ch,
  ukcd_chan_if.sink    cfg_ch
);

  logic [15:0]                     reload_r;
  logic [ukcd_pkg::SCALE_W-1:0]    scale_r;
  logic                            s1_vld_r;
  logic [7:0]                      s1_byte_r;
  logic                            out_vld_r;
  ukcd_pkg::out_beat_t             out_r;

  logic                            s1_adv;
  logic                            res_vld;
  ukcd_pkg::out_beat_t             res;
  ukcd_pkg::in_beat_t              in_beat;
  logic                            in_take;

  assign in_beat = in_ch.data;
  assign s1_adv  = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_take = in_ch.valid && in_ch.ready;

  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= ukcd_pkg::RELOAD_RESET;
      scale_r  <= ukcd_pkg::SCALE_RESET;
    end else begin
      if (cfg_ch.valid) reload_r <= cfg_ch.data;
      scale_r <= ukcd_pkg::reload_scale(reload_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_byte_r <= in_beat.rx_byte;
  end

  ukcd_line #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .rx_byte (s1_byte_r),
    .scale   (scale_r),
    .res_vld (res_vld),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= res_vld;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_vld) out_r <= res;
  end

  `ASSERT_CLK(a_ready_when_free, clk, rst_n, !out_vld_r |-> in_ch.ready)
  `ASSERT_CLK(a_result_from_step, clk, rst_n, $rose(out_vld_r) |-> $past(s1_vld_r))
  `ASSERT_CLK(a_echo_beat, clk, rst_n,
    s1_adv && s1_byte_r != ukcd_pkg::CH_CR && s1_byte_r != ukcd_pkg::CH_LF |=>
      out_vld_r && out_r.kind == ukcd_pkg::KIND_ECHO && out_r.echo_byte == $past(s1_byte_r))

endmodule

// ===== dv/tb.sv =====
module tb;

  logic clk;
  logic rst_n;

  ukcd_chan_if #(.payload_t(ukcd_pkg::in_beat_t))  in_if ();
  ukcd_chan_if #(.payload_t(ukcd_pkg::out_beat_t)) out_if ();
  ukcd_chan_if #(.payload_t(ukcd_pkg::cfg_beat_t)) cfg_if ();

  uart_kv_command_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_MOSTLY} rx_mode_t;

  // line decoder prediction state
  logic [15:0]       cur_reload;
  logic [4:0]        line_len;
  ukcd_pkg::phase_t  line_phase;
  logic [15:0]       key_bytes;
  logic [1:0]        key_len;
  logic [31:0]       val_mag;
  logic              val_neg;
  logic              line_bad;
  logic              text_done;

  ukcd_pkg::out_beat_t expected_beats[$];

  int  err_count = 0;
  int  sent_count = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b1;
  bit  hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    err_count++;
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------- prediction ----------------
  function automatic bit blank_char(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit num_char(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic bit key_char(input logic [7:0] c);
    return num_char(c) || (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic void clear_line();
    line_len   = '0;
    line_phase = ukcd_pkg::PH_LEAD;
    key_bytes  = '0;
    key_len    = '0;
    val_mag    = '0;
    val_neg    = 1'b0;
    line_bad   = 1'b0;
    text_done  = 1'b0;
  endfunction

  function automatic void add_digit(input logic [7:0] c);
    logic [35:0] m;
    m = 36'(val_mag) * 36'd10 + 36'(c - ukcd_pkg::CH_ZERO);
    val_mag = (m > 36'(ukcd_pkg::MAG_CAP)) ? ukcd_pkg::MAG_CAP : m[31:0];
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    if (c == ukcd_pkg::CH_NUL) begin
      text_done = 1'b1;
      return;
    end
    if (line_bad) return;
    case (line_phase)
      ukcd_pkg::PH_LEAD: begin
        if (!blank_char(c)) begin
          if (key_char(c)) begin
            key_bytes  = {8'd0, c};
            key_len    = 2'd1;
            line_phase = ukcd_pkg::PH_KEY;
          end else begin
            line_bad = 1'b1;
          end
        end
      end
      ukcd_pkg::PH_KEY: begin
        if (c == ukcd_pkg::CH_EQ) begin
          line_phase = ukcd_pkg::PH_VLEAD;
        end else if (key_char(c) && key_len == 2'd1) begin
          key_bytes[15:8] = c;
          key_len = 2'd2;
        end else begin
          line_bad = 1'b1;
        end
      end
      ukcd_pkg::PH_VLEAD: begin
        if (!blank_char(c)) begin
          if (c == ukcd_pkg::CH_PLUS || c == ukcd_pkg::CH_MINUS) begin
            val_neg    = (c == ukcd_pkg::CH_MINUS);
            line_phase = ukcd_pkg::PH_SIGN;
          end else if (num_char(c)) begin
            add_digit(c);
            line_phase = ukcd_pkg::PH_DIGITS;
          end else begin
            line_bad = 1'b1;
          end
        end
      end
      ukcd_pkg::PH_SIGN: begin
        if (num_char(c)) begin
          add_digit(c);
          line_phase = ukcd_pkg::PH_DIGITS;
        end else begin
          line_bad = 1'b1;
        end
      end
      ukcd_pkg::PH_DIGITS: begin
        if (num_char(c)) add_digit(c);
        else if (blank_char(c)) line_phase = ukcd_pkg::PH_TRAIL;
        else line_bad = 1'b1;
      end
      ukcd_pkg::PH_TRAIL: begin
        if (!blank_char(c)) line_bad = 1'b1;
      end
      default: line_bad = 1'b1;
    endcase
  endfunction

  function automatic bit close_line(output ukcd_pkg::out_beat_t r);
    longint      v;
    longint      av;
    longint      p;
    logic [7:0]  duty;
    logic [63:0] cmp;
    r = '0;
    if (line_bad || !(line_phase == ukcd_pkg::PH_DIGITS || line_phase == ukcd_pkg::PH_TRAIL) ||
        key_len != 2'd1)
      return 1'b0;
    if (val_neg) v = -longint'({32'd0, val_mag});
    else if (val_mag > 32'h7FFF_FFFF) v = 64'sd2147483647;
    else v = longint'({32'd0, val_mag});
    if (key_bytes[7:0] == ukcd_pkg::KEY_SERVO) begin
      // 340 and 330 are the half spans below and above mid; / truncates toward zero
      if (v < 0) p = 1470 + (340 * v) / 34;
      else p = 1470 + (330 * v) / 34;
      r.kind = ukcd_pkg::KIND_SERVO;
      r.servo_pulse = p[15:0];
      return 1'b1;
    end
    if (key_bytes[7:0] == ukcd_pkg::KEY_FWD || key_bytes[7:0] == ukcd_pkg::KEY_REV) begin
      av = (key_bytes[7:0] == ukcd_pkg::KEY_REV && v < 0) ? -v : v;
      duty = av[7:0];
      if (duty > 8'(ukcd_pkg::DUTY_MAX)) duty = 8'(ukcd_pkg::DUTY_MAX);
      cmp = (64'(cur_reload) * 64'(duty)) / 64'd100;
      r.kind = ukcd_pkg::KIND_MOTOR;
      r.motor_dir = (key_bytes[7:0] == ukcd_pkg::KEY_FWD) ? ukcd_pkg::DIR_FWD
                                                          : ukcd_pkg::DIR_REV;
      r.motor_compare = cmp[15:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    ukcd_pkg::out_beat_t r;
    r = '0;
    if (b == ukcd_pkg::CH_CR || b == ukcd_pkg::CH_LF) begin
      if (line_len != 5'd0) begin
        if (close_line(r)) expected_beats.push_back(r);
      end
      clear_line();
    end else begin
      r.kind = ukcd_pkg::KIND_ECHO;
      r.echo_byte = b;
      expected_beats.push_back(r);
      if (line_len < 5'(ukcd_pkg::LINE_BYTES_DEF - 1)) begin
        line_len++;
        if (!text_done) parse_char(b);
      end else begin
        clear_line();
      end
    end
  endfunction

  // ---------------- result checking ----------------
  initial begin : result_check
    ukcd_pkg::out_beat_t got;
    ukcd_pkg::out_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_beats.size() == 0) begin
          report_error("unexpected beat, kind", 32'(got.kind), 32'd0);
        end else begin
          want = expected_beats.pop_front();
          if (got.kind != want.kind)
            report_error("kind", 32'(got.kind), 32'(want.kind));
          if (got.echo_byte != want.echo_byte)
            report_error("echo_byte", 32'(got.echo_byte), 32'(want.echo_byte));
          if (got.servo_pulse != want.servo_pulse)
            report_error("servo_pulse", 32'(got.servo_pulse), 32'(want.servo_pulse));
          if (got.motor_dir != want.motor_dir)
            report_error("motor_dir", 32'(got.motor_dir), 32'(want.motor_dir));
          if (got.motor_compare != want.motor_compare)
            report_error("motor_compare", 32'(got.motor_compare), 32'(want.motor_compare));
        end
      end
    end
  end

  // ---------------- receiver side ----------------
  initial begin : rx_side
    rx_mode_t mode;
    int run_left;
    int hold_left;
    int tick;
    mode = RX_OPEN;
    run_left = 0;
    hold_left = 0;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 100;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          run_left = $urandom_range(8, 64);
        end
        run_left--;
        case (mode)
          RX_OPEN:    out_if.ready <= 1'b1;
          RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
          RX_QUARTER: out_if.ready <= (tick % 4 == 0);
          default:    out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------- sender side ----------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    do @(posedge clk); while (!in_if.ready);
    sent_count++;
    decode_byte(b);
  endtask

  task automatic send_line(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_beats.size() != 0) @(posedge clk);
    // a line end may still be in flight with nothing to show for it
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reload(input logic [15:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_reload = v;
    repeat (3) @(posedge clk);
  endtask

  // ---------------- random line content ----------------
  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0: return 8'd9;
      1: return 8'd11;
      2: return 8'd12;
      default: return 8'd32;
    endcase
  endfunction

  function automatic logic [7:0] pick_alnum();
    int n;
    n = $urandom_range(0, 61);
    if (n < 10) return 8'(48 + n);
    if (n < 36) return 8'(65 + n - 10);
    return 8'(97 + n - 36);
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == ukcd_pkg::CH_CR || b == ukcd_pkg::CH_LF) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic void append_command(ref logic [7:0] q[$]);
    int sel;
    int ndig;
    repeat ($urandom_range(0, 2)) q.push_back(pick_blank());
    sel = $urandom_range(0, 99);
    if (sel < 40) q.push_back(ukcd_pkg::KEY_SERVO);
    else if (sel < 65) q.push_back(ukcd_pkg::KEY_FWD);
    else if (sel < 90) q.push_back(ukcd_pkg::KEY_REV);
    else q.push_back(pick_alnum());
    if ($urandom_range(0, 9) == 0) q.push_back(pick_alnum());
    q.push_back(ukcd_pkg::CH_EQ);
    repeat ($urandom_range(0, 2)) q.push_back(pick_blank());
    case ($urandom_range(0, 2))
      1: q.push_back(ukcd_pkg::CH_PLUS);
      2: q.push_back(ukcd_pkg::CH_MINUS);
      default: ;
    endcase
    // long digit runs can hit saturation
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
    repeat (ndig) q.push_back(8'(ukcd_pkg::CH_ZERO + $urandom_range(0, 9)));
    repeat ($urandom_range(0, 2)) q.push_back(pick_blank());
  endfunction

  task automatic send_random_line();
    logic [7:0] q[$];
    int sel;
    int pos;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      append_command(q);
    end else if (sel < 80) begin
      append_command(q);
      pos = $urandom_range(0, q.size() - 1);
      q[pos] = pick_noise();
    end else if (sel < 86) begin
      append_command(q);
      pos = $urandom_range(0, q.size());
      q.insert(pos, ukcd_pkg::CH_NUL);
    end else if (sel < 92) begin
      // overrun: 32nd byte drops the line, the rest starts a new one
      repeat ($urandom_range(31, 33)) q.push_back(pick_noise());
      append_command(q);
    end else begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
    end
    q.push_back($urandom_range(0, 1) ? ukcd_pkg::CH_CR : ukcd_pkg::CH_LF);
    if ($urandom_range(0, 7) == 0) q.push_back(ukcd_pkg::CH_LF);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_commands();
    send_byte(ukcd_pkg::CH_CR);
    send_line("x=+7 ", ukcd_pkg::CH_LF);
    send_line("x=-2147483649", ukcd_pkg::CH_CR);
    send_line("x=99999999999", ukcd_pkg::CH_CR);
    send_line(" z=-300\t", ukcd_pkg::CH_CR);
    send_line("r=-57", ukcd_pkg::CH_LF);
    send_line("r=0", ukcd_pkg::CH_CR);
    send_line("q=1", ukcd_pkg::CH_CR);
    send_line("xy=1", ukcd_pkg::CH_CR);
    send_line("x=1a", ukcd_pkg::CH_CR);
    send_line("x=", ukcd_pkg::CH_CR);
    send_line("   ", ukcd_pkg::CH_CR);
    // text after a NUL is counted but never parsed
    send_line("z=5", ukcd_pkg::CH_NUL);
    send_line("9", ukcd_pkg::CH_CR);
    send_byte(8'hFF);
    send_byte(ukcd_pkg::CH_CR);
  endtask

  task automatic test_line_full();
    // exactly LINE_BYTES-1 stored bytes is still a usable line
    repeat (27) send_byte(8'd32);
    send_line("x=1 ", ukcd_pkg::CH_CR);
    repeat (31) send_byte(8'd98);
    send_byte(ukcd_pkg::CH_PLUS);
    send_line("z=50", ukcd_pkg::CH_LF);
  endtask

  task automatic test_backpressure();
    int start;
    gaps_on = 1'b0;
    start = sent_count;
    hold_request = 1'b1;
    while (sent_count - start < 40) send_random_line();
    drain_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_random(input int n);
    int start;
    start = sent_count;
    gaps_on = ($urandom_range(0, 3) != 0);
    while (sent_count - start < n) send_random_line();
    gaps_on = 1'b1;
  endtask

  initial begin : main_seq
    int waited;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    rst_n        <= 1'b0;
    cur_reload = ukcd_pkg::RELOAD_RESET;
    clear_line();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_commands();
    test_line_full();
    write_reload(16'd0);
    test_random(40);
    write_reload(16'hFFFF);
    test_backpressure();
    test_random(80);
    write_reload(16'($urandom_range(0, 65535)));
    test_random(80);
    write_reload(16'd1);
    test_random(40);
    write_reload(ukcd_pkg::RELOAD_RESET);
    test_random(40);

    in_if.valid <= 1'b0;
    waited = 0;
    while (expected_beats.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_beats.size() != 0)
      report_error("beats never delivered", 32'(expected_beats.size()), 32'd0);

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
